@@ sv/lssd_pkg.sv @@
package lssd_pkg;

  // Scan length bound: counters saturate here.
  localparam int MAX_RAYS = 4096;
  localparam int COUNT_W  = $clog2(MAX_RAYS + 1);
  localparam int INDEX_W  = $clog2(MAX_RAYS);
  localparam int RANGE_W  = 16;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BAND      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RANGE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RUN   = 2'd2;

  localparam logic [RANGE_W-1:0] BAND_RESET      = 16'd50;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 16'd1500;
  localparam logic [COUNT_W-1:0] MIN_RUN_RESET   = 13'd30;

  localparam logic [RANGE_W-1:0] RANGE_ALL_ONES = '1;

  typedef struct packed {
    logic [RANGE_W-1:0] band_mm;
    logic [RANGE_W-1:0] max_range_mm;
    logic [COUNT_W-1:0] min_run_rays;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_mm;
    logic               range_finite;
    logic               last_ray;
  } ray_t;

  typedef struct packed {
    logic               stuck_found;
    logic [INDEX_W-1:0] stuck_start;
    logic [COUNT_W-1:0] stuck_length;
    logic [RANGE_W-1:0] stuck_level_mm;
    logic [COUNT_W-1:0] finite_total;
    logic [RANGE_W-1:0] finite_min_mm;
    logic [RANGE_W-1:0] finite_max_mm;
  } result_t;

endpackage

@@ sv/lssd_ray_if.sv @@
interface lssd_ray_if;
  logic                        valid;
  logic                        ready;
  logic [lssd_pkg::RANGE_W-1:0] range_mm;
  logic                        range_finite;
  logic                        last_ray;

  modport source (output valid, output range_mm, output range_finite, output last_ray,
                  input ready);
  modport sink (input valid, input range_mm, input range_finite, input last_ray,
                output ready);
endinterface

@@ sv/lssd_result_if.sv @@
interface lssd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        stuck_found;
  logic [lssd_pkg::INDEX_W-1:0] stuck_start;
  logic [lssd_pkg::COUNT_W-1:0] stuck_length;
  logic [lssd_pkg::RANGE_W-1:0] stuck_level_mm;
  logic [lssd_pkg::COUNT_W-1:0] finite_total;
  logic [lssd_pkg::RANGE_W-1:0] finite_min_mm;
  logic [lssd_pkg::RANGE_W-1:0] finite_max_mm;

  modport source (output valid, output stuck_found, output stuck_start,
                  output stuck_length, output stuck_level_mm, output finite_total,
                  output finite_min_mm, output finite_max_mm, input ready);
  modport sink (input valid, input stuck_found, input stuck_start,
                input stuck_length, input stuck_level_mm, input finite_total,
                input finite_min_mm, input finite_max_mm, output ready);
endinterface

@@ sv/lssd_cfg_regs.sv @@
module lssd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lssd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lssd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output lssd_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band_mm      <= lssd_pkg::BAND_RESET;
      cfg.max_range_mm <= lssd_pkg::MAX_RANGE_RESET;
      cfg.min_run_rays <= lssd_pkg::MIN_RUN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        lssd_pkg::REG_BAND:      cfg.band_mm      <= cfg_data[lssd_pkg::RANGE_W-1:0];
        lssd_pkg::REG_MAX_RANGE: cfg.max_range_mm <= cfg_data[lssd_pkg::RANGE_W-1:0];
        lssd_pkg::REG_MIN_RUN:   cfg.min_run_rays <= cfg_data[lssd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/lssd_scan_core.sv @@
module lssd_scan_core (
  input  logic              clk,
  input  logic              rst,
  input  lssd_pkg::cfg_t    cfg,
  input  logic              step,
  input  lssd_pkg::ray_t    ray,
  output lssd_pkg::result_t result
);

  localparam logic [lssd_pkg::COUNT_W-1:0] CNT_MAX  = lssd_pkg::COUNT_W'(lssd_pkg::MAX_RAYS);
  localparam logic [lssd_pkg::INDEX_W-1:0] IDX_LAST =
    lssd_pkg::INDEX_W'(lssd_pkg::MAX_RAYS - 1);

  logic                         in_run;
  logic [lssd_pkg::INDEX_W-1:0] cur_start;
  logic [lssd_pkg::COUNT_W-1:0] cur_len;
  logic [lssd_pkg::RANGE_W-1:0] cur_low;
  logic [lssd_pkg::RANGE_W-1:0] cur_high;
  logic [lssd_pkg::INDEX_W-1:0] best_begin;
  logic [lssd_pkg::COUNT_W-1:0] best_count;
  logic [lssd_pkg::RANGE_W-1:0] best_mid;
  logic [lssd_pkg::COUNT_W-1:0] ray_index;
  logic [lssd_pkg::COUNT_W-1:0] valid_count;
  logic [lssd_pkg::RANGE_W-1:0] valid_low;
  logic [lssd_pkg::RANGE_W-1:0] valid_high;

  logic                         in_run_next;
  logic [lssd_pkg::INDEX_W-1:0] cur_start_next;
  logic [lssd_pkg::COUNT_W-1:0] cur_len_next;
  logic [lssd_pkg::RANGE_W-1:0] cur_low_next;
  logic [lssd_pkg::RANGE_W-1:0] cur_high_next;
  logic [lssd_pkg::INDEX_W-1:0] best_begin_next;
  logic [lssd_pkg::COUNT_W-1:0] best_count_next;
  logic [lssd_pkg::RANGE_W-1:0] best_mid_next;
  logic [lssd_pkg::COUNT_W-1:0] ray_index_next;
  logic [lssd_pkg::COUNT_W-1:0] valid_count_next;
  logic [lssd_pkg::RANGE_W-1:0] valid_low_next;
  logic [lssd_pkg::RANGE_W-1:0] valid_high_next;

  logic                         qual;
  logic [lssd_pkg::RANGE_W-1:0] lo;
  logic [lssd_pkg::RANGE_W-1:0] hi;
  logic [lssd_pkg::RANGE_W-1:0] spread;
  logic [lssd_pkg::INDEX_W-1:0] start_idx;
  logic [lssd_pkg::RANGE_W:0]   cur_sum;
  logic [lssd_pkg::RANGE_W:0]   next_sum;
  logic                         close_wins;
  logic                         final_wins;

  always_comb begin
    qual      = ray.range_finite && (ray.range_mm < cfg.max_range_mm);
    lo        = (ray.range_mm < cur_low) ? ray.range_mm : cur_low;
    hi        = (ray.range_mm > cur_high) ? ray.range_mm : cur_high;
    spread    = hi - lo;
    start_idx = (ray_index >= CNT_MAX) ? IDX_LAST : ray_index[lssd_pkg::INDEX_W-1:0];
    cur_sum   = {1'b0, cur_low} + {1'b0, cur_high};
    // The open run beats the best one only when strictly longer.
    close_wins = in_run && (cur_len > best_count);

    in_run_next     = in_run;
    cur_start_next  = cur_start;
    cur_len_next    = cur_len;
    cur_low_next    = cur_low;
    cur_high_next   = cur_high;
    best_begin_next = best_begin;
    best_count_next = best_count;
    best_mid_next   = best_mid;

    if (qual && in_run && (spread <= cfg.band_mm)) begin
      cur_low_next  = lo;
      cur_high_next = hi;
      if (cur_len < CNT_MAX) begin
        cur_len_next = cur_len + 1'b1;
      end
    end else begin
      // Either the run ends here, or a new run starts at this ray because none was
      // open or the ray broke the band.
      if (close_wins) begin
        best_count_next = cur_len;
        best_begin_next = cur_start;
        best_mid_next   = cur_sum[lssd_pkg::RANGE_W:1];
      end
      in_run_next = qual;
      if (qual) begin
        cur_start_next = start_idx;
        cur_len_next   = lssd_pkg::COUNT_W'(1);
        cur_low_next   = ray.range_mm;
        cur_high_next  = ray.range_mm;
      end
    end

    valid_count_next = valid_count;
    valid_low_next   = valid_low;
    valid_high_next  = valid_high;
    if (ray.range_finite) begin
      if (valid_count < CNT_MAX) begin
        valid_count_next = valid_count + 1'b1;
      end
      if (ray.range_mm < valid_low) begin
        valid_low_next = ray.range_mm;
      end
      if (ray.range_mm > valid_high) begin
        valid_high_next = ray.range_mm;
      end
    end

    ray_index_next = (ray_index < CNT_MAX) ? ray_index + 1'b1 : ray_index;

    // End of scan closes whatever run is still open.
    next_sum   = {1'b0, cur_low_next} + {1'b0, cur_high_next};
    final_wins = in_run_next && (cur_len_next > best_count_next);

    result.stuck_start    = final_wins ? cur_start_next : best_begin_next;
    result.stuck_length   = final_wins ? cur_len_next : best_count_next;
    result.stuck_level_mm = final_wins ? next_sum[lssd_pkg::RANGE_W:1] : best_mid_next;
    result.stuck_found    = (result.stuck_length >= cfg.min_run_rays);
    result.finite_total   = valid_count_next;
    result.finite_min_mm  = valid_low_next;
    result.finite_max_mm  = valid_high_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && ray.last_ray)) begin
      in_run      <= 1'b0;
      cur_start   <= '0;
      cur_len     <= '0;
      cur_low     <= '0;
      cur_high    <= '0;
      best_begin  <= '0;
      best_count  <= '0;
      best_mid    <= '0;
      ray_index   <= '0;
      valid_count <= '0;
      valid_low   <= lssd_pkg::RANGE_ALL_ONES;
      valid_high  <= '0;
    end else if (step) begin
      in_run      <= in_run_next;
      cur_start   <= cur_start_next;
      cur_len     <= cur_len_next;
      cur_low     <= cur_low_next;
      cur_high    <= cur_high_next;
      best_begin  <= best_begin_next;
      best_count  <= best_count_next;
      best_mid    <= best_mid_next;
      ray_index   <= ray_index_next;
      valid_count <= valid_count_next;
      valid_low   <= valid_low_next;
      valid_high  <= valid_high_next;
    end
  end

`ifndef ASSERT_OFF
  a_best_within_index: assert property (@(posedge clk) disable iff (rst)
    best_count <= ray_index)
    else $error("best run longer than rays seen");

  a_finite_within_index: assert property (@(posedge clk) disable iff (rst)
    valid_count <= ray_index)
    else $error("finite count exceeds rays seen");

  a_run_within_index: assert property (@(posedge clk) disable iff (rst)
    in_run |-> (cur_len <= ray_index) && (cur_len != '0))
    else $error("open run length inconsistent with ray index");

  a_run_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    in_run |-> cur_low <= cur_high)
    else $error("open run minimum above maximum");
`endif

endmodule

@@ sv/lidar_stuck_sector_detector.sv @@
// Lidar stuck-sector detector. Each transaction on the ray channel carries one
// ray of a scan: range_mm, range_finite and last_ray. The block counts finite
// rays with their minimum and maximum range, and finds the longest run of
// consecutive finite rays below max_range_mm whose spread stays within band_mm
// (a ray that breaks the band starts a new run; among equal lengths the earliest
// run wins). The ray marked last produces one result transaction with the stuck
// verdict (length at least min_run_rays), run start, length, midpoint level and
// the finite statistics, and the scan state then clears. Throughput is one ray
// per clock while the ray channel does not stall: a ray is registered on
// acceptance, its whole state update is done when it leaves that stage, and a
// result lands in an output register. While a result waits in that register,
// non-last rays keep flowing; only a second last ray held behind an untaken
// result stalls the ray channel. A last ray's result passes the ray stage
// register and then the output register before it becomes valid. Counters
// saturate at 4096 rays. Configuration writes take effect on the next clock
// and are meant to be made between transactions.
module lidar_stuck_sector_detector (
  input  logic                              clk,
  input  logic                              rst,
  lssd_ray_if.sink                          ray,
  lssd_result_if.source                     result,
  input  logic                              cfg_write,
  input  logic [lssd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lssd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lssd_pkg::cfg_t    cfg;
  lssd_pkg::ray_t    stage_ray;
  lssd_pkg::result_t scan_result;
  lssd_pkg::result_t out_reg;
  logic              stage_valid;
  logic              out_valid;
  logic              advance;

  lssd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The staged ray is processed this cycle unless it is a last ray and the
  // output register still holds a result that is not being taken.
  assign advance   = stage_valid && (!stage_ray.last_ray || !out_valid || result.ready);
  assign ray.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (ray.ready) begin
      stage_valid <= ray.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ray.valid && ray.ready) begin
      stage_ray.range_mm     <= ray.range_mm;
      stage_ray.range_finite <= ray.range_finite;
      stage_ray.last_ray     <= ray.last_ray;
    end
  end

  lssd_scan_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .ray    (stage_ray),
    .result (scan_result)
  );

  // Output register: loaded by a last ray, emptied when the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_ray.last_ray) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_ray.last_ray) begin
      out_reg <= scan_result;
    end
  end

  assign result.valid          = out_valid;
  assign result.stuck_found    = out_reg.stuck_found;
  assign result.stuck_start    = out_reg.stuck_start;
  assign result.stuck_length   = out_reg.stuck_length;
  assign result.stuck_level_mm = out_reg.stuck_level_mm;
  assign result.finite_total   = out_reg.finite_total;
  assign result.finite_min_mm  = out_reg.finite_min_mm;
  assign result.finite_max_mm  = out_reg.finite_max_mm;

`ifndef ASSERT_OFF
  a_result_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> out_valid && $stable(out_reg))
    else $error("pending result lost or changed while stalled");

  a_stall_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |-> stage_ray.last_ray && out_valid)
    else $error("ray stage stalled without a pending result");

  a_stage_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> stage_valid && $stable(stage_ray))
    else $error("staged ray dropped while stalled");
`endif

endmodule
